@@ hw/rtl/etrm_pkg.sv @@
// ----------------------------------------------------------------------------
// etrm_pkg - shared constants for the Euler-angle rotation matrix block
// CORDIC gain in Q.30, pi and arctangent table in Q.20, datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none
package etrm_pkg;
   localparam int ANGLE_BITS   = 16;
   localparam int ELEMENT_BITS = 16;
   localparam int CORDIC_ITERS = 20;
   localparam int XY_BITS      = 34;   // Q.30 with headroom
   localparam int Z_BITS       = 26;   // Q.20 angle with headroom
   localparam logic signed [XY_BITS-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [Z_BITS-1:0]  PI_HALF_Q20     = 26'sd1647099;
   localparam logic signed [Z_BITS-1:0]  PI_Q20          = 26'sd3294199;

   function automatic logic signed [Z_BITS-1:0] atan_q20(input logic [4:0] i);
      logic signed [Z_BITS-1:0] v;
      case (i)
         5'd0:  v = 26'sd823550;
         5'd1:  v = 26'sd486170;
         5'd2:  v = 26'sd256879;
         5'd3:  v = 26'sd130396;
         5'd4:  v = 26'sd65451;
         5'd5:  v = 26'sd32757;
         5'd6:  v = 26'sd16383;
         5'd7:  v = 26'sd8192;
         5'd8:  v = 26'sd4096;
         5'd9:  v = 26'sd2048;
         5'd10: v = 26'sd1024;
         5'd11: v = 26'sd512;
         5'd12: v = 26'sd256;
         5'd13: v = 26'sd128;
         5'd14: v = 26'sd64;
         5'd15: v = 26'sd32;
         5'd16: v = 26'sd16;
         5'd17: v = 26'sd8;
         5'd18: v = 26'sd4;
         5'd19: v = 26'sd2;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Q.30 product rounded back to Q.30
   function automatic logic signed [XY_BITS-1:0] mul_q30(
         input logic signed [XY_BITS-1:0] a, input logic signed [XY_BITS-1:0] b);
      logic signed [2*XY_BITS-1:0] p;
      p = a * b + (68'sd1 <<< 29);
      return p[XY_BITS+29:30];
   endfunction
endpackage
`default_nettype wire

@@ hw/rtl/etrm_cordic.sv @@
// ----------------------------------------------------------------------------
// etrm_cordic - pipelined CORDIC cosine/sine
// Folds the angle into +-pi/2, then one rotation step per stage; payload
// moves only when the stage enable is high.
// ----------------------------------------------------------------------------
`default_nettype none
module etrm_cordic #(
   parameter int ANGLE_BITS = etrm_pkg::ANGLE_BITS
) (
   input  wire  logic                                 clock,
   input  wire  logic                                 enable,
   input  wire  logic signed [ANGLE_BITS-1:0]         angle,
   output logic signed [etrm_pkg::XY_BITS-1:0]        cos_out,
   output logic signed [etrm_pkg::XY_BITS-1:0]        sin_out
);
   localparam int N  = etrm_pkg::CORDIC_ITERS;
   localparam int XB = etrm_pkg::XY_BITS;
   localparam int ZB = etrm_pkg::Z_BITS;
   localparam int FRAC = ANGLE_BITS - 3;

   logic signed [ZB-1:0] z0;
   logic signed [ZB-1:0] zf_in;
   logic                 flip_in;
   logic signed [XB-1:0] x_ff [N+1];
   logic signed [XB-1:0] y_ff [N+1];
   logic signed [ZB-1:0] z_ff [N+1];
   logic                 flip_ff [N+1];

   always_comb begin
      if (FRAC <= 20) begin
         z0 = ZB'(signed'(angle)) <<< (FRAC <= 20 ? 20 - FRAC : 0);
      end else begin
         z0 = ZB'(signed'(angle) >>> (FRAC > 20 ? FRAC - 20 : 0));
      end
      flip_in = 1'b1;
      if (z0 > etrm_pkg::PI_HALF_Q20) begin
         zf_in = z0 - etrm_pkg::PI_Q20;
      end else if (z0 < -etrm_pkg::PI_HALF_Q20) begin
         zf_in = z0 + etrm_pkg::PI_Q20;
      end else begin
         zf_in   = z0;
         flip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]    <= etrm_pkg::CORDIC_GAIN_Q30;
         y_ff[0]    <= '0;
         z_ff[0]    <= zf_in;
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      always_ff @(posedge clock) begin
         if (enable) begin
            flip_ff[i+1] <= flip_ff[i];
            if (z_ff[i] >= 0) begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - etrm_pkg::atan_q20(5'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + etrm_pkg::atan_q20(5'(i));
            end
         end
      end
   end

   assign cos_out = flip_ff[N] ? -x_ff[N] : x_ff[N];
   assign sin_out = flip_ff[N] ? -y_ff[N] : y_ff[N];
endmodule
`default_nettype wire

@@ hw/rtl/etrm_matrix.sv @@
// ----------------------------------------------------------------------------
// etrm_matrix - products and sums for the nine matrix terms
// Stage A: pair products, stage B: triple products, stage C: sums, stage D:
// rounding to Q1.x with saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module etrm_matrix #(
   parameter int ELEMENT_BITS = etrm_pkg::ELEMENT_BITS
) (
   input  wire  logic                                clock,
   input  wire  logic                                enable,
   input  wire  logic signed [etrm_pkg::XY_BITS-1:0] c0, s0, c1, s1, c2, s2,
   output logic signed [ELEMENT_BITS-1:0]            elem_ff [9]
);
   localparam int XB = etrm_pkg::XY_BITS;
   localparam int SH = 30 - (ELEMENT_BITS - 2);
   localparam logic signed [XB-1:0] LIM = XB'(1) <<< (ELEMENT_BITS - 2);

   logic signed [XB-1:0] c0s1_ff, s0s1_ff, s0c2_ff, s0s2_ff, c0c2_ff, c0s2_ff;
   logic signed [XB-1:0] c0c1_ff, s0c1_ff, c1s2_ff, c1c2_ff, ns1_ff;
   logic signed [XB-1:0] c2b_ff, s2b_ff;
   logic signed [XB-1:0] t_ff [9];
   logic signed [XB-1:0] p1_ff, p2_ff, p3_ff, p4_ff;
   logic signed [XB-1:0] q_ff [9];

   function automatic logic signed [ELEMENT_BITS-1:0] to_elem(
         input logic signed [XB-1:0] v);
      logic signed [XB:0] ve;
      logic signed [XB:0] lim_e;
      logic signed [XB:0] r;
      ve    = (XB+1)'(v);
      lim_e = (XB+1)'(LIM);
      r = (SH == 0) ? ve : ((ve + ((XB+1)'(1) <<< (SH - 1))) >>> SH);
      if (r > lim_e) r = lim_e;
      if (r < -lim_e) r = -lim_e;
      return r[ELEMENT_BITS-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (enable) begin
         c0s1_ff <= etrm_pkg::mul_q30(c0, s1);
         s0s1_ff <= etrm_pkg::mul_q30(s0, s1);
         s0c2_ff <= etrm_pkg::mul_q30(s0, c2);
         s0s2_ff <= etrm_pkg::mul_q30(s0, s2);
         c0c2_ff <= etrm_pkg::mul_q30(c0, c2);
         c0s2_ff <= etrm_pkg::mul_q30(c0, s2);
         c0c1_ff <= etrm_pkg::mul_q30(c0, c1);
         s0c1_ff <= etrm_pkg::mul_q30(s0, c1);
         c1s2_ff <= etrm_pkg::mul_q30(c1, s2);
         c1c2_ff <= etrm_pkg::mul_q30(c1, c2);
         ns1_ff  <= -s1;
         c2b_ff  <= c2;
         s2b_ff  <= s2;
         p1_ff <= etrm_pkg::mul_q30(c0s1_ff, s2b_ff);
         p2_ff <= etrm_pkg::mul_q30(c0s1_ff, c2b_ff);
         p3_ff <= etrm_pkg::mul_q30(s0s1_ff, s2b_ff);
         p4_ff <= etrm_pkg::mul_q30(s0s1_ff, c2b_ff);
         q_ff[0] <= c0c1_ff;
         q_ff[1] <= s0c2_ff;
         q_ff[2] <= s0s2_ff;
         q_ff[3] <= s0c1_ff;
         q_ff[4] <= c0c2_ff;
         q_ff[5] <= c0s2_ff;
         q_ff[6] <= ns1_ff;
         q_ff[7] <= c1s2_ff;
         q_ff[8] <= c1c2_ff;
         t_ff[0] <= q_ff[0];
         t_ff[1] <= p1_ff - q_ff[1];
         t_ff[2] <= p2_ff + q_ff[2];
         t_ff[3] <= q_ff[3];
         t_ff[4] <= p3_ff + q_ff[4];
         t_ff[5] <= p4_ff - q_ff[5];
         t_ff[6] <= q_ff[6];
         t_ff[7] <= q_ff[7];
         t_ff[8] <= q_ff[8];
         for (int k = 0; k < 9; k++) elem_ff[k] <= to_elem(t_ff[k]);
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/euler_to_rotation_matrix.sv @@
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix - ZYX Euler angles to rotation matrix
// Three angles in, nine matrix elements out in row-major order.
// ----------------------------------------------------------------------------
// One request of three angles yields nine responses, one per cycle while
// rsp_stall is low; the nine-element serialiser on the output limits the
// request rate, but the pipeline takes new requests while one is serialised.
// The CORDIC and multiply pipeline has 25 stages and the serialiser holds one
// more request, so up to 26 requests are in flight. The whole pipeline halts
// while its last stage and the serialiser are both full.
`default_nettype none
module euler_to_rotation_matrix #(
   parameter int ANGLE_BITS   = etrm_pkg::ANGLE_BITS,
   parameter int ELEMENT_BITS = etrm_pkg::ELEMENT_BITS
) (
   input  wire  logic                           clock,
   input  wire  logic                           reset,
   input  wire  logic                           req_valid,
   output logic                                 req_stall,
   input  wire  logic signed [ANGLE_BITS-1:0]   req_angle_first,
   input  wire  logic signed [ANGLE_BITS-1:0]   req_angle_second,
   input  wire  logic signed [ANGLE_BITS-1:0]   req_angle_third,
   output logic                                 rsp_valid,
   input  wire  logic                           rsp_stall,
   output logic [1:0]                           rsp_row_index,
   output logic [1:0]                           rsp_col_index,
   output logic signed [ELEMENT_BITS-1:0]       rsp_global_to_local,
   output logic signed [ELEMENT_BITS-1:0]       rsp_local_to_global,
   output logic                                 rsp_last
);
   localparam int DEPTH = etrm_pkg::CORDIC_ITERS + 1 + 4;
   localparam int XB = etrm_pkg::XY_BITS;

   logic enable;
   logic [DEPTH-1:0] vld_ff;
   logic signed [XB-1:0] c0, s0, c1, s1, c2, s2;
   logic signed [ELEMENT_BITS-1:0] elem [9];
   logic signed [ELEMENT_BITS-1:0] hold_ff [9];
   logic busy_ff;
   logic [3:0] cnt_ff;
   logic [1:0] row_ff, col_ff;
   logic load;
   logic done;

   assign done = busy_ff && !rsp_stall && cnt_ff == 4'd8;
   // pipeline moves unless its last stage holds a result and the
   // serialiser cannot take it
   assign enable = !(vld_ff[DEPTH-1] && busy_ff && !done);
   assign load = vld_ff[DEPTH-1] && enable;
   assign req_stall = !enable;

   etrm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cs0 (.clock, .enable,
      .angle(req_angle_first), .cos_out(c0), .sin_out(s0));
   etrm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cs1 (.clock, .enable,
      .angle(req_angle_second), .cos_out(c1), .sin_out(s1));
   etrm_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cs2 (.clock, .enable,
      .angle(req_angle_third), .cos_out(c2), .sin_out(s2));
   etrm_matrix #(.ELEMENT_BITS(ELEMENT_BITS)) u_mat (.clock, .enable,
      .c0, .s0, .c1, .s1, .c2, .s2, .elem_ff(elem));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         if (enable) vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
         if (load) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            row_ff  <= '0;
            col_ff  <= '0;
         end else if (busy_ff && !rsp_stall) begin
            if (cnt_ff == 4'd8) busy_ff <= 1'b0;
            cnt_ff <= cnt_ff + 4'd1;
            if (col_ff == 2'd2) begin
               col_ff <= '0;
               row_ff <= row_ff + 2'd1;
            end else begin
               col_ff <= col_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) hold_ff <= elem;
   end

   assign rsp_valid = busy_ff;
   assign rsp_row_index = row_ff;
   assign rsp_col_index = col_ff;
   assign rsp_global_to_local = hold_ff[4'(row_ff) * 4'd3 + 4'(col_ff)];
   assign rsp_local_to_global = hold_ff[4'(col_ff) * 4'd3 + 4'(row_ff)];
   assign rsp_last = cnt_ff == 4'd8;

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= 4'd8) else $error("element count overrun");
   a_rowcol: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> row_ff != 2'd3 && col_ff != 2'd3) else $error("bad index");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      busy_ff && rsp_stall |=> busy_ff && $stable(cnt_ff))
      else $error("response lost under stall");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> vld_ff[DEPTH-1] && busy_ff) else $error("spurious stall");
endmodule
`default_nettype wire

@@ bench/tb_euler_to_rotation_matrix.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_to_rotation_matrix - self-checking bench for the Euler rotation block
// Drives angle triples with random gaps, stalls the response side at random,
// and checks each of the nine elements per request against a bit-exact CORDIC
// model of the ZYX matrix and its transpose, or typed-in identity values.
// ----------------------------------------------------------------------------
module tb_euler_to_rotation_matrix;

   localparam int N_RANDOM    = 200;
   localparam int CYCLE_LIMIT = 200000;
   localparam int LATENCY     = 60;

   typedef struct packed {
      logic [1:0]         row;
      logic [1:0]         col;
      logic signed [15:0] g2l;
      logic signed [15:0] l2g;
      logic               last;
   } element_type;

   typedef struct {
      logic signed [15:0] a0, a1, a2;
      bit                 fixed;   // expected values typed in
      logic signed [15:0] diag;    // element (0,0) and (1,1),(2,2)
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_angle_first = '0, req_angle_second = '0, req_angle_third = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_row_index, rsp_col_index;
   logic signed [15:0] rsp_global_to_local, rsp_local_to_global;
   logic rsp_last;

   element_type elements_due[$];
   int  errors = 0;
   int  cycles = 0;
   int  requests_sent = 0;
   int  elements_seen = 0;
   bit  sender_done = 1'b0;
   bit  long_hold = 1'b0;

   euler_to_rotation_matrix dut (
      .clock, .reset, .req_valid, .req_stall,
      .req_angle_first, .req_angle_second, .req_angle_third,
      .rsp_valid, .rsp_stall, .rsp_row_index, .rsp_col_index,
      .rsp_global_to_local, .rsp_local_to_global, .rsp_last
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint floor_sh(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint rmul(longint a, longint b);
      return (a * b + (64'sd1 << 29)) >>> 30;
   endfunction

   function automatic void cordic_cos_sin(logic signed [15:0] ang,
                                          output longint c, output longint s);
      longint z, x, y, dx, dy;
      bit flip;
      z = longint'(ang) * 128;
      x = 652032874;
      y = 0;
      flip = 1'b0;
      if (z > 1647099) begin
         z -= 3294199; flip = 1'b1;
      end else if (z < -1647099) begin
         z += 3294199; flip = 1'b1;
      end
      for (int i = 0; i < 20; i++) begin
         dx = floor_sh(y, i);
         dy = floor_sh(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(etrm_pkg::atan_q20(5'(i)));
         end else begin
            x += dx; y -= dy; z += longint'(etrm_pkg::atan_q20(5'(i)));
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic logic signed [15:0] q14_sat(longint v);
      longint r;
      r = (v + (64'sd1 << 15)) >>> 16;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return 16'(r);
   endfunction

   function automatic void predict_matrix(logic signed [15:0] a0, a1, a2);
      longint c0, s0, c1, s1, c2, s2;
      longint m[3][3];
      element_type e;
      cordic_cos_sin(a0, c0, s0);
      cordic_cos_sin(a1, c1, s1);
      cordic_cos_sin(a2, c2, s2);
      m[0][0] = rmul(c0, c1);
      m[0][1] = rmul(rmul(c0, s1), s2) - rmul(s0, c2);
      m[0][2] = rmul(rmul(c0, s1), c2) + rmul(s0, s2);
      m[1][0] = rmul(s0, c1);
      m[1][1] = rmul(rmul(s0, s1), s2) + rmul(c0, c2);
      m[1][2] = rmul(rmul(s0, s1), c2) - rmul(c0, s2);
      m[2][0] = -s1;
      m[2][1] = rmul(c1, s2);
      m[2][2] = rmul(c1, c2);
      for (int r = 0; r < 3; r++)
         for (int k = 0; k < 3; k++) begin
            e.row = 2'(r);
            e.col = 2'(k);
            e.g2l = q14_sat(m[r][k]);
            e.l2g = q14_sat(m[k][r]);
            e.last = (r == 2 && k == 2);
            elements_due.push_back(e);
         end
   endfunction

   // called at a falling edge; leaves valid high with the taken request until
   // the next call either replaces it or drops valid
   task automatic send_request(logic signed [15:0] a0, a1, a2);
      int gap;
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_angle_first <= a0;
      req_angle_second <= a1;
      req_angle_third <= a2;
      predict_matrix(a0, a1, a2);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
      @(negedge clock);
   endtask

   // sender
   initial begin
      stim_type table_rows[$];
      stim_type row;
      element_type head;
      int n_fixed;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // zero angles give the identity: checked against typed-in values
      table_rows.push_back('{16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd16384});
      table_rows.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, '0});
      table_rows.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0});
      table_rows.push_back('{16'sh7fff, 16'sh8000, 16'sd0, 1'b0, '0});
      table_rows.push_back('{16'sd12868, 16'sd0, 16'sd0, 1'b0, '0});   // pi/2
      table_rows.push_back('{16'sd0, 16'sd12868, 16'sd0, 1'b0, '0});
      table_rows.push_back('{16'sd0, 16'sd0, 16'sd12868, 1'b0, '0});
      table_rows.push_back('{16'sd12869, -16'sd12869, 16'sd12867, 1'b0, '0});
      table_rows.push_back('{16'sd25736, 16'sd25736, -16'sd25736, 1'b0, '0}); // pi
      table_rows.push_back('{16'sh5555, 16'shaaaa, 16'sh5555, 1'b0, '0});
      table_rows.push_back('{16'shaaaa, 16'sh5555, 16'shaaaa, 1'b0, '0});
      table_rows.push_back('{16'sd1, -16'sd1, 16'sd1, 1'b0, '0});
      table_rows.push_back('{16'sd6434, 16'sd6434, 16'sd6434, 1'b0, '0});
      foreach (table_rows[i]) begin
         row = table_rows[i];
         send_request(row.a0, row.a1, row.a2);
         n_fixed = elements_due.size() - 9;
         if (row.fixed) begin
            // identity: overwrite prediction with literal expectation
            for (int j = 0; j < 9; j++) begin
               head = elements_due[n_fixed + j];
               head.g2l = (head.row == head.col) ? row.diag : 16'sd0;
               head.l2g = head.g2l;
               elements_due[n_fixed + j] = head;
            end
         end
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 40) long_hold = 1'b1;
         if (i == 120) begin
            // drain completely before continuing
            req_valid <= 1'b0;
            @(negedge clock);
            while (elements_due.size() != 0) @(negedge clock);
         end
         send_request(16'($urandom), 16'($urandom), 16'($urandom));
      end
      req_valid <= 1'b0;
      sender_done = 1'b1;
   end

   // receiver stall pattern
   initial begin
      int hold;
      @(negedge clock);
      while (1) begin
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
         end
         hold = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(negedge clock);
      end
   end

   // response checker
   always @(posedge clock) begin
      element_type exp_e;
      if (!reset && rsp_valid && !rsp_stall) begin
         elements_seen++;
         if (elements_due.size() == 0) begin
            $error("unexpected response row %0d col %0d", rsp_row_index, rsp_col_index);
            errors++;
         end else begin
            exp_e = elements_due.pop_front();
            if (rsp_row_index !== exp_e.row) begin
               $error("row_index: expected %0d, got %0d", exp_e.row, rsp_row_index);
               errors++;
            end
            if (rsp_col_index !== exp_e.col) begin
               $error("col_index: expected %0d, got %0d", exp_e.col, rsp_col_index);
               errors++;
            end
            if (rsp_global_to_local !== exp_e.g2l) begin
               $error("global_to_local: expected %0d, got %0d", exp_e.g2l,
                      rsp_global_to_local);
               errors++;
            end
            if (rsp_local_to_global !== exp_e.l2g) begin
               $error("local_to_global: expected %0d, got %0d", exp_e.l2g,
                      rsp_local_to_global);
               errors++;
            end
            if (rsp_last !== exp_e.last) begin
               $error("last: expected %0d, got %0d", exp_e.last, rsp_last);
               errors++;
            end
         end
      end
   end

   // end of run and watchdog
   initial begin
      while (!(sender_done && elements_due.size() == 0)) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      $display("Run covered %0d requests and %0d matrix elements, with long output hold.",
               requests_sent, elements_seen);
      if (errors == 0 && elements_due.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end
endmodule

@@ files.f @@
hw/rtl/etrm_pkg.sv
hw/rtl/etrm_cordic.sv
hw/rtl/etrm_matrix.sv
hw/rtl/euler_to_rotation_matrix.sv
bench/tb_euler_to_rotation_matrix.sv
